// ===== hw/rtl/cell_list_neighbor_search_macros.svh =====
// Assertion macros for the cell list neighbour search block.
// Used by the modules that carry checks; needs clk_i and rst_ni in scope.
`ifndef CELL_LIST_NEIGHBOR_SEARCH_MACROS_SVH
`define CELL_LIST_NEIGHBOR_SEARCH_MACROS_SVH
`ifndef SYNTHESIS
`define CLNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define CLNS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define CLNS_ASSERT(lbl, prop, msg)
`define CLNS_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ===== hw/rtl/clns_pkg.sv =====
// Shared types, constants and offset tables of the cell list neighbour search.
// No dependencies.
`timescale 1ns / 1ps
package clns_pkg;
  localparam int NPART_DEF  = 64;
  localparam int NCELLS_DEF = 4096;
  localparam int MAX_RES    = 64;
  localparam int COORD_W    = 32;
  localparam int CELLS_W    = 13;
  localparam int HS_W       = 34;
  localparam int CIDX_W     = 35;
  localparam int NXY_W      = 2 * CELLS_W;
  localparam logic [6:0] EMPTY_ID = 7'h7F;
  localparam logic [6:0] NONE_ID  = 7'd64;

  typedef enum logic [1:0] {
    FN_CLEAR  = 2'd0,
    FN_INSERT = 2'd1,
    FN_QUERY  = 2'd2,
    FN_SCAN   = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    REG_DIMS  = 3'd0,
    REG_ORG_X = 3'd1,
    REG_ORG_Y = 3'd2,
    REG_ORG_Z = 3'd3,
    REG_INV   = 3'd4,
    REG_CX    = 3'd5,
    REG_CY    = 3'd6,
    REG_CZ    = 3'd7
  } reg_e;

  typedef struct packed {
    logic [1:0]                 dims;
    logic [2:0][COORD_W-1:0]    origin;
    logic [COORD_W-1:0]         inv;
    logic [2:0][CELLS_W-1:0]    cells;
    logic [NXY_W-1:0]           nxy;
  } cfg_t;

  typedef struct packed {
    func_e                      func;
    logic [5:0]                 pid;
    logic [2:0][HS_W-1:0]       hs;
  } cmd_t;

  typedef struct packed {
    logic [6:0] self_id;
    logic [5:0] nb;
    logic       found;
    logic       last;
    logic       status;
  } res_t;

  typedef struct packed {
    logic signed [1:0] x;
    logic signed [1:0] y;
    logic signed [1:0] z;
  } off_t;

  function automatic logic [1:0] act_dims(logic [1:0] d);
    return (d == 2'd0) ? 2'd1 : d;
  endfunction

  // half scan visiting order: centre, +x, y+1 row, z+1 plane
  function automatic off_t scan_off(logic [3:0] s);
    off_t o;
    case (s)
      4'd0:    o = '{2'sd0,  2'sd0,  2'sd0};
      4'd1:    o = '{2'sd1,  2'sd0,  2'sd0};
      4'd2:    o = '{-2'sd1, 2'sd1,  2'sd0};
      4'd3:    o = '{2'sd0,  2'sd1,  2'sd0};
      4'd4:    o = '{2'sd1,  2'sd1,  2'sd0};
      4'd5:    o = '{-2'sd1, -2'sd1, 2'sd1};
      4'd6:    o = '{2'sd0,  -2'sd1, 2'sd1};
      4'd7:    o = '{2'sd1,  -2'sd1, 2'sd1};
      4'd8:    o = '{-2'sd1, 2'sd0,  2'sd1};
      4'd9:    o = '{2'sd0,  2'sd0,  2'sd1};
      4'd10:   o = '{2'sd1,  2'sd0,  2'sd1};
      4'd11:   o = '{-2'sd1, 2'sd1,  2'sd1};
      4'd12:   o = '{2'sd0,  2'sd1,  2'sd1};
      4'd13:   o = '{2'sd1,  2'sd1,  2'sd1};
      default: o = '{2'sd0,  2'sd0,  2'sd0};
    endcase
    return o;
  endfunction

  function automatic logic [3:0] scan_last(logic [1:0] ad);
    logic [3:0] r;
    case (ad)
      2'd1:    r = 4'd1;
      2'd2:    r = 4'd4;
      default: r = 4'd13;
    endcase
    return r;
  endfunction
endpackage

// ===== hw/rtl/clns_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module clns_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/clns_cmd_fifo.sv =====
// Two-entry command queue between the front and back parts.
// Depends on clns_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cell_list_neighbor_search_macros.svh"
module clns_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_valid_i,
  output logic          wr_ready_o,
  input  clns_pkg::cmd_t wr_data_i,
  output logic          rd_valid_o,
  input  logic          rd_ready_i,
  output clns_pkg::cmd_t rd_data_o
);
  import clns_pkg::*;

  cmd_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign wr_ready_o = (cnt_q != 2'd2);
  assign rd_valid_o = (cnt_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        mem_q[wp_q] <= wr_data_i;
        wp_q        <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `CLNS_ASSERT(a_fifo_cnt, cnt_q <= 2'd2, "queue count past depth")
  `CLNS_ASSERT(a_fifo_ptr, (cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q,
               "queue pointers disagree with count")
  `CLNS_ASSERT(a_fifo_one, cnt_q == 2'd1 |-> wp_q != rp_q, "queue pointers equal at one word")
endmodule

// ===== hw/rtl/clns_front.sv =====
// Front part: takes input words and works out the cell index of each axis.
// Depends on clns_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "cell_list_neighbor_search_macros.svh"
module clns_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clns_pkg::cfg_t cfg_i,
  input  logic           hold_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [1:0]     func_i,
  input  logic [5:0]     particle_id_i,
  input  logic [31:0]    coord_x_i,
  input  logic [31:0]    coord_y_i,
  input  logic [31:0]    coord_z_i,
  output logic           cmd_valid_o,
  input  logic           cmd_ready_i,
  output clns_pkg::cmd_t cmd_o
);
  import clns_pkg::*;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_IDX  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_e;

  fstate_e                 state_q;
  func_e                   func_q;
  logic [5:0]              pid_q;
  logic [COORD_W-1:0]      crd_q [3];
  logic [1:0]              axis_q;
  logic [64:0]             prod_q;
  logic                    neg_q;
  logic [2:0][HS_W-1:0]    hs_q;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic [64:0]        prod_d;
  logic [65:0]        rnd;
  logic [64:0]        sub;
  logic [HS_W-1:0]    idx;
  logic               active;

  always_comb begin
    diff   = $signed({crd_q[axis_q][31], crd_q[axis_q]})
           - $signed({cfg_i.origin[axis_q][31], cfg_i.origin[axis_q]});
    mag    = diff[32] ? 33'(-diff) : 33'(diff);
    prod_d = 65'(mag) * 65'(cfg_i.inv);
    rnd    = 66'(prod_q) + 66'h0_8000_0000;
    sub    = prod_q - 65'h0_8000_0000;
    if (!neg_q) begin
      idx = rnd[65:32];
    end else if (prod_q <= 65'h0_8000_0000) begin
      idx = '0;
    end else begin
      idx = HS_W'(-$signed({1'b0, sub[64:32]}));
    end
    active = axis_q < act_dims(cfg_i.dims);
  end

  assign in_ready_o  = (state_q == F_IDLE) && !hold_i;
  assign cmd_valid_o = (state_q == F_PUSH);
  assign cmd_o       = '{func: func_q, pid: pid_q, hs: hs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      axis_q  <= 2'd0;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            func_q   <= func_e'(func_i);
            pid_q    <= particle_id_i;
            crd_q[0] <= coord_x_i;
            crd_q[1] <= coord_y_i;
            crd_q[2] <= coord_z_i;
            axis_q   <= 2'd0;
            state_q  <= F_MUL;
          end
        end
        F_MUL: begin
          prod_q  <= prod_d;
          neg_q   <= diff[32];
          state_q <= F_IDX;
        end
        F_IDX: begin
          hs_q[axis_q] <= active ? idx : '0;
          if (axis_q == 2'd2) begin
            state_q <= F_PUSH;
          end else begin
            axis_q  <= axis_q + 2'd1;
            state_q <= F_MUL;
          end
        end
        F_PUSH: begin
          if (cmd_ready_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

  `CLNS_ASSERT(a_axis_rng, state_q != F_IDLE |-> axis_q != 2'd3, "axis counter out of range")
  `CLNS_ASSERT(a_push_after_z, $rose(cmd_valid_o) |-> $past(axis_q) == 2'd2,
               "command pushed before all axes done")
  `CLNS_ASSERT(a_idle_take, in_valid_i && in_ready_o |=> state_q == F_MUL,
               "accepted word did not start the multiply")
endmodule

// ===== hw/rtl/clns_back.sv =====
// Back part: clear sweep, insert, and the cell walks of point query and half scan.
// Depends on clns_pkg, clns_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "cell_list_neighbor_search_macros.svh"
module clns_back #(
  parameter int unsigned NPART  = clns_pkg::NPART_DEF,
  parameter int unsigned NCELLS = clns_pkg::NCELLS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  clns_pkg::cfg_t cfg_i,
  input  clns_pkg::cmd_t cmd_i,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  output logic           init_busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output clns_pkg::res_t res_o
);
  import clns_pkg::*;

  localparam int HAW = $clog2(NCELLS);
  localparam int LAW = $clog2(NPART);
  localparam int SW  = $clog2(NPART + 1);
  localparam int FW  = CELLS_W + NXY_W + 1;

  typedef enum logic [9:0] {
    B_SWEEP = 10'b0000000001,
    B_IDLE  = 10'b0000000010,
    B_CELL  = 10'b0000000100,
    B_FLAT  = 10'b0000001000,
    B_INS   = 10'b0000010000,
    B_HEAD  = 10'b0000100000,
    B_WALK  = 10'b0001000000,
    B_LINK  = 10'b0010000000,
    B_FIN   = 10'b0100000000,
    B_SPARE = 10'b1000000000
  } bstate_e;

  bstate_e              state_q;
  logic                 init_q;
  logic [HAW-1:0]       clr_q;
  cmd_t                 cmd_q;
  off_t                 off_q;
  logic [3:0]           step_q;
  logic [CELLS_W-1:0]   cx_q;
  logic [NXY_W-1:0]     py_q;
  logic [NXY_W+CELLS_W-1:0] pz_q;
  logic                 inr_q;
  logic [HAW-1:0]       flat_q;
  logic [6:0]           it_q;
  logic [SW-1:0]        steps_q;
  logic [6:0]           n_q;
  logic                 pend_v_q;
  logic [5:0]           pend_nb_q;
  logic                 stat_q;
  logic                 lv_rd_q;
  logic [NPART-1:0]     lv_q;
  logic                 out_valid_q;
  res_t                 out_q;

  logic [6:0]           head_rdata, link_rdata;
  logic                 head_we, link_we;
  logic [HAW-1:0]       head_waddr;
  logic [6:0]           head_wdata;

  logic [1:0]                ad;
  logic signed [1:0]         yhi, zhi;
  logic signed [1:0]         offs [3];
  logic signed [CIDX_W-1:0]  c [3];
  logic                      inr_c;
  logic [NXY_W-1:0]          py_c;
  logic [NXY_W+CELLS_W-1:0]  pz_c;
  logic [FW-1:0]             f_c;
  logic                      flat_ok, pid_ok, it_ok, walk_end, cap_hit;
  logic [6:0]                self_c;
  logic                      filter, emit_c, out_free, walk_go;
  logic                      adv_done;
  off_t                      off_nxt;
  logic                      push_c;
  res_t                      push_res;

  always_comb begin
    ad      = act_dims(cfg_i.dims);
    yhi     = (ad > 2'd1) ? 2'sd1 : 2'sd0;
    zhi     = (ad > 2'd2) ? 2'sd1 : 2'sd0;
    offs[0] = off_q.x;
    offs[1] = off_q.y;
    offs[2] = off_q.z;
    inr_c   = 1'b1;
    for (int k = 0; k < 3; k++) begin
      c[k] = CIDX_W'($signed(cmd_q.hs[k])) + CIDX_W'(offs[k]);
      if ((2'(k) < ad) && (c[k] < 0
          || c[k] >= $signed({(CIDX_W - CELLS_W)'(0), cfg_i.cells[k]}))) begin
        inr_c = 1'b0;
      end
    end
    py_c    = NXY_W'(cfg_i.cells[0]) * NXY_W'(c[1][CELLS_W-1:0]);
    pz_c    = (NXY_W + CELLS_W)'(cfg_i.nxy) * (NXY_W + CELLS_W)'(c[2][CELLS_W-1:0]);
    f_c     = FW'(cx_q) + FW'(py_q) + FW'(pz_q);
    flat_ok = inr_q && (f_c < FW'(NCELLS));
    pid_ok  = {1'b0, cmd_q.pid} < 7'(NPART);
    it_ok   = it_q < 7'(NPART);
    walk_end = !it_ok || (steps_q == SW'(NPART));
    cap_hit = (n_q == 7'(MAX_RES));
    self_c  = (cmd_q.func == FN_SCAN || cmd_q.func == FN_INSERT) ? {1'b0, cmd_q.pid}
                                                                  : NONE_ID;
    filter  = (cmd_q.func == FN_SCAN) && (step_q == 4'd0);
    emit_c  = (!filter || self_c > it_q) && (self_c != it_q);
    out_free = !out_valid_q || out_ready_i;
    walk_go = (state_q == B_WALK) && !walk_end && !cap_hit
           && !(emit_c && pend_v_q && !out_free);

    // next cell of the neighbourhood
    off_nxt = off_q;
    if (cmd_q.func == FN_QUERY) begin
      adv_done = (off_q.x == 2'sd1) && (off_q.y == yhi) && (off_q.z == zhi);
      if (off_q.z != zhi) begin
        off_nxt.z = off_q.z + 2'sd1;
      end else begin
        off_nxt.z = -zhi;
        if (off_q.y != yhi) begin
          off_nxt.y = off_q.y + 2'sd1;
        end else begin
          off_nxt.y = -yhi;
          off_nxt.x = off_q.x + 2'sd1;
        end
      end
    end else begin
      adv_done = (step_q == scan_last(ad));
      off_nxt  = scan_off(step_q + 4'd1);
    end

    push_c   = 1'b0;
    push_res = '{self_id: self_c, nb: pend_nb_q, found: 1'b1, last: 1'b0, status: 1'b0};
    if (walk_go && emit_c && pend_v_q) begin
      push_c = 1'b1;
    end else if (state_q == B_FIN && out_free) begin
      push_c = 1'b1;
      if (pend_v_q) begin
        push_res.last = 1'b1;
      end else begin
        push_res = '{self_id: self_c, nb: 6'd0, found: 1'b0, last: 1'b1, status: stat_q};
      end
    end

    head_we    = (state_q == B_SWEEP) || (state_q == B_INS);
    head_waddr = (state_q == B_SWEEP) ? clr_q : flat_q;
    head_wdata = (state_q == B_SWEEP) ? EMPTY_ID : {1'b0, cmd_q.pid};
    link_we    = (state_q == B_INS);
  end

  clns_ram #(.WIDTH(7), .DEPTH(NCELLS)) u_heads (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (head_waddr),
    .wdata_i (head_wdata),
    .raddr_i (f_c[HAW-1:0]),
    .rdata_o (head_rdata)
  );

  clns_ram #(.WIDTH(7), .DEPTH(NPART)) u_links (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (cmd_q.pid[LAW-1:0]),
    .wdata_i (head_rdata),
    .raddr_i (it_q[LAW-1:0]),
    .rdata_o (link_rdata)
  );

  assign cmd_ready_o = (state_q == B_IDLE);
  assign init_busy_o = (state_q == B_SWEEP) && init_q;
  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_SWEEP;
      init_q      <= 1'b1;
      clr_q       <= '0;
      lv_q        <= '0;
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
      n_q         <= 7'd0;
      step_q      <= 4'd0;
      steps_q     <= '0;
    end else begin
      if (push_c) begin
        out_valid_q <= 1'b1;
        out_q       <= push_res;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_SWEEP: begin
          if (clr_q == HAW'(NCELLS - 1)) begin
            clr_q   <= '0;
            init_q  <= 1'b0;
            state_q <= init_q ? B_IDLE : B_FIN;
          end else begin
            clr_q <= clr_q + HAW'(1);
          end
        end
        B_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q    <= cmd_i;
            n_q      <= 7'd0;
            pend_v_q <= 1'b0;
            stat_q   <= 1'b0;
            step_q   <= 4'd0;
            case (cmd_i.func)
              FN_CLEAR: begin
                lv_q    <= '0;
                off_q   <= '{2'sd0, 2'sd0, 2'sd0};
                state_q <= B_SWEEP;
              end
              FN_QUERY: begin
                off_q   <= '{-2'sd1, -yhi, -zhi};
                state_q <= B_CELL;
              end
              default: begin
                off_q   <= '{2'sd0, 2'sd0, 2'sd0};
                state_q <= B_CELL;
              end
            endcase
          end
        end
        B_CELL: begin
          cx_q    <= c[0][CELLS_W-1:0];
          py_q    <= py_c;
          pz_q    <= pz_c;
          inr_q   <= inr_c;
          state_q <= B_FLAT;
        end
        B_FLAT: begin
          if (cmd_q.func == FN_INSERT) begin
            if (flat_ok && pid_ok) begin
              flat_q  <= f_c[HAW-1:0];
              state_q <= B_INS;
            end else begin
              stat_q  <= 1'b1;
              state_q <= B_FIN;
            end
          end else if (flat_ok) begin
            steps_q <= '0;
            state_q <= B_HEAD;
          end else if (adv_done) begin
            state_q <= B_FIN;
          end else begin
            off_q   <= off_nxt;
            step_q  <= step_q + 4'd1;
            state_q <= B_CELL;
          end
        end
        B_INS: begin
          lv_q[cmd_q.pid[LAW-1:0]] <= 1'b1;
          state_q                  <= B_FIN;
        end
        B_HEAD: begin
          it_q    <= head_rdata;
          state_q <= B_WALK;
        end
        B_WALK: begin
          if (walk_end) begin
            if (adv_done) begin
              state_q <= B_FIN;
            end else begin
              off_q   <= off_nxt;
              step_q  <= step_q + 4'd1;
              state_q <= B_CELL;
            end
          end else if (cap_hit) begin
            state_q <= B_FIN;
          end else if (walk_go) begin
            if (emit_c) begin
              pend_v_q  <= 1'b1;
              pend_nb_q <= it_q[5:0];
              n_q       <= n_q + 7'd1;
            end
            lv_rd_q <= lv_q[it_q[LAW-1:0]];
            steps_q <= steps_q + SW'(1);
            state_q <= B_LINK;
          end
        end
        B_LINK: begin
          it_q    <= lv_rd_q ? link_rdata : EMPTY_ID;
          state_q <= B_WALK;
        end
        B_FIN: begin
          if (out_free) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  `CLNS_ASSERT_NEVER(a_no_overrun, out_valid_q && !out_ready_i && push_c,
                     "result word overwritten while stalled")
  `CLNS_ASSERT(a_res_cap, n_q <= 7'(MAX_RES), "result count past limit")
  `CLNS_ASSERT(a_cap_ends, state_q == B_WALK && !walk_end && cap_hit |=> state_q == B_FIN,
               "walk went on after the result limit")
  `CLNS_ASSERT(a_link_order, state_q == B_LINK |-> $past(state_q) == B_WALK,
               "link read without a walk step")
  `CLNS_ASSERT(a_steps_cap, steps_q <= SW'(NPART), "chain walk longer than particle count")
endmodule

// ===== hw/rtl/cell_list_neighbor_search.sv =====
// Cell list neighbour search: top level with config registers, front, queue and back.
// Cell list neighbour search top level.
// Depends on clns_pkg, clns_front, clns_cmd_fifo and clns_back.
//
// Input channel (in_valid_i/in_ready_o) takes one word per operation: clear,
// insert, point query or half scan. Output channel (out_valid_o/out_ready_i)
// gives one word per reported neighbour; last_o marks the final word of an
// operation, and operations that find nothing give a single word with found 0.
// Config writes (cfg_valid_i, cfg_index_i, cfg_data_i) are always taken.
// The front does the per-axis multiply on one shared 33x32 multiplier, one
// axis at a time, and takes a new word only once its last command is in the
// queue; a two-word queue lets it run ahead.
// Back: a point query visits up to 27 cells and a half scan up to 14; for each
// cell inside the grid it reads the head entry and walks the chain, one link
// read per entry; clear sweeps the head table, one entry per cycle.
// After reset the head table is swept with in_ready_o low.
// A stalled receiver holds one result in the output register; the back part
// then waits and the queue fills, after which in_ready_o drops.
`timescale 1ns / 1ps
module cell_list_neighbor_search #(
  parameter int unsigned NPART  = clns_pkg::NPART_DEF,
  parameter int unsigned NCELLS = clns_pkg::NCELLS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [5:0]  particle_id_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  self_id_o,
  output logic [5:0]  neighbor_id_o,
  output logic        found_o,
  output logic        last_o,
  output logic        status_o
);
  import clns_pkg::*;

  cfg_t cfg_q;
  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready, init_busy;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dims   <= 2'd3;
      cfg_q.origin <= '0;
      cfg_q.inv    <= 32'd65536;
      cfg_q.cells  <= {3{13'd16}};
      cfg_q.nxy    <= NXY_W'(256);
    end else begin
      cfg_q.nxy <= NXY_W'(cfg_q.cells[0]) * NXY_W'(cfg_q.cells[1]);
      if (cfg_valid_i) begin
        case (reg_e'(cfg_index_i))
          REG_DIMS:  cfg_q.dims      <= cfg_data_i[1:0];
          REG_ORG_X: cfg_q.origin[0] <= cfg_data_i;
          REG_ORG_Y: cfg_q.origin[1] <= cfg_data_i;
          REG_ORG_Z: cfg_q.origin[2] <= cfg_data_i;
          REG_INV:   cfg_q.inv       <= cfg_data_i;
          REG_CX:    cfg_q.cells[0]  <= cfg_data_i[CELLS_W-1:0];
          REG_CY:    cfg_q.cells[1]  <= cfg_data_i[CELLS_W-1:0];
          REG_CZ:    cfg_q.cells[2]  <= cfg_data_i[CELLS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  clns_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .hold_i        (init_busy),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .func_i        (func_i),
    .particle_id_i (particle_id_i),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .coord_z_i     (coord_z_i),
    .cmd_valid_o   (f_valid),
    .cmd_ready_i   (f_ready),
    .cmd_o         (f_cmd)
  );

  clns_cmd_fifo u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  (f_cmd),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_cmd)
  );

  clns_back #(.NPART(NPART), .NCELLS(NCELLS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (b_cmd),
    .cmd_valid_i (b_valid),
    .cmd_ready_o (b_ready),
    .init_busy_o (init_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign self_id_o     = res.self_id;
  assign neighbor_id_o = res.nb;
  assign found_o       = res.found;
  assign last_o        = res.last;
  assign status_o      = res.status;
endmodule

// ===== tb/sv/cell_list_checker.sv =====
// Checker for the cell list neighbour search: watches the config, input and output channels,
// predicts every output word from its own copy of the grid, and counts mismatches.
// Depends on clns_pkg.
`timescale 1ns / 1ps
module cell_list_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  func_i,
  input  logic [5:0]  particle_id_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [6:0]  self_id_i,
  input  logic [5:0]  neighbor_id_i,
  input  logic        found_i,
  input  logic        last_i,
  input  logic        status_i,
  output int          fail_count_o,
  output int          pending_o
);
  import clns_pkg::*;

  localparam int NP = 64;
  localparam int NC = 4096;

  logic [1:0]  dims_q;
  logic [31:0] origin_q [3];
  logic [31:0] inv_q;
  logic [12:0] cells_q [3];
  logic [6:0]  heads [NC];
  logic [6:0]  links [NP];
  res_t        expected_words [$];
  res_t        batch [$];

  assign pending_o = expected_words.size();

  function automatic longint cell_of(logic [31:0] coord, logic [31:0] org);
    longint d;
    logic [63:0] m;
    d = longint'($signed(coord)) - longint'($signed(org));
    if (d >= 0) begin
      m = 64'(d) * 64'(inv_q);
      return longint'((m + 64'h8000_0000) >> 32);
    end
    m = 64'(-d) * 64'(inv_q);
    if (m <= 64'h8000_0000) return 0;
    return -longint'((m - 64'h8000_0000) >> 32);
  endfunction

  function automatic int n_axes();
    return (dims_q == 2'd0) ? 1 : int'(dims_q);
  endfunction

  // returns -1 when outside the grid or past the head table
  function automatic longint flat_of(longint c [3]);
    longint f, mul;
    f = 0;
    mul = 1;
    for (int k = 0; k < n_axes(); k++)
      if (c[k] < 0 || c[k] >= longint'(cells_q[k])) return -1;
    for (int k = 0; k < n_axes(); k++) begin
      f += c[k] * mul;
      mul *= longint'(cells_q[k]);
    end
    return (f >= NC) ? -1 : f;
  endfunction

  task automatic walk_cell(longint hs [3], int ox, int oy, int oz, logic [6:0] self,
                           bit lower_only);
    longint c [3];
    longint f;
    logic [6:0] it;
    res_t r;
    c[0] = hs[0] + ox;
    c[1] = hs[1] + oy;
    c[2] = hs[2] + oz;
    f = flat_of(c);
    if (f < 0) return;
    it = heads[f];
    for (int s = 0; it < NP && s < NP; s++) begin
      if (batch.size() >= MAX_RES) return;
      if ((!lower_only || self > it) && self != it) begin
        r = '{self_id: self, nb: it[5:0], found: 1'b1, last: 1'b0, status: 1'b0};
        batch.push_back(r);
      end
      it = links[it[5:0]];
    end
  endtask

  task automatic predict(logic [1:0] fn, logic [5:0] pid, logic [31:0] cx,
                         logic [31:0] cy, logic [31:0] cz);
    longint hs [3];
    longint f;
    int lo_y, lo_z;
    res_t r;
    batch.delete();
    hs = '{0, 0, 0};
    if (fn == FN_CLEAR) begin
      foreach (heads[i]) heads[i] = EMPTY_ID;
      foreach (links[i]) links[i] = EMPTY_ID;
      expected_words.push_back('{NONE_ID, 6'd0, 1'b0, 1'b1, 1'b0});
      return;
    end
    hs[0] = cell_of(cx, origin_q[0]);
    if (n_axes() > 1) hs[1] = cell_of(cy, origin_q[1]);
    if (n_axes() > 2) hs[2] = cell_of(cz, origin_q[2]);
    if (fn == FN_INSERT) begin
      f = flat_of(hs);
      if (f < 0) begin
        expected_words.push_back('{{1'b0, pid}, 6'd0, 1'b0, 1'b1, 1'b1});
      end else begin
        links[pid] = heads[f];
        heads[f] = {1'b0, pid};
        expected_words.push_back('{{1'b0, pid}, 6'd0, 1'b0, 1'b1, 1'b0});
      end
      return;
    end
    if (fn == FN_QUERY) begin
      lo_y = n_axes() > 1 ? -1 : 0;
      lo_z = n_axes() > 2 ? -1 : 0;
      for (int x = -1; x <= 1; x++)
        for (int y = lo_y; y <= -lo_y; y++)
          for (int z = lo_z; z <= -lo_z; z++)
            walk_cell(hs, x, y, z, NONE_ID, 1'b0);
      if (batch.size() == 0) batch.push_back('{NONE_ID, 6'd0, 1'b0, 1'b0, 1'b0});
    end else begin
      walk_cell(hs, 0, 0, 0, {1'b0, pid}, 1'b1);
      walk_cell(hs, 1, 0, 0, {1'b0, pid}, 1'b0);
      if (n_axes() > 1) begin
        for (int x = -1; x <= 1; x++) walk_cell(hs, x, 1, 0, {1'b0, pid}, 1'b0);
        if (n_axes() > 2)
          for (int y = -1; y <= 1; y++)
            for (int x = -1; x <= 1; x++) walk_cell(hs, x, y, 1, {1'b0, pid}, 1'b0);
      end
      if (batch.size() == 0) batch.push_back('{{1'b0, pid}, 6'd0, 1'b0, 1'b0, 1'b0});
    end
    batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_words.push_back(batch[i]);
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      dims_q = 2'd3;
      for (int k = 0; k < 3; k++) begin
        origin_q[k] = '0;
        cells_q[k] = 13'd16;
      end
      inv_q = 32'd65536;
      foreach (heads[i]) heads[i] = EMPTY_ID;
      foreach (links[i]) links[i] = EMPTY_ID;
      expected_words.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_DIMS:  dims_q = cfg_data_i[1:0];
          REG_ORG_X: origin_q[0] = cfg_data_i;
          REG_ORG_Y: origin_q[1] = cfg_data_i;
          REG_ORG_Z: origin_q[2] = cfg_data_i;
          REG_INV:   inv_q = cfg_data_i;
          REG_CX:    cells_q[0] = cfg_data_i[12:0];
          REG_CY:    cells_q[1] = cfg_data_i[12:0];
          REG_CZ:    cells_q[2] = cfg_data_i[12:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        predict(func_i, particle_id_i, coord_x_i, coord_y_i, coord_z_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_words.size() == 0) begin
          report("unexpected output word count", 1, 0);
        end else begin
          e = expected_words.pop_front();
          if (self_id_i !== e.self_id) report("self_id", self_id_i, e.self_id);
          if (neighbor_id_i !== e.nb) report("neighbor_id", neighbor_id_i, e.nb);
          if (found_i !== e.found) report("found", found_i, e.found);
          if (last_i !== e.last) report("last", last_i, e.last);
          if (status_i !== e.status) report("status", status_i, e.status);
        end
      end
    end
  end
endmodule

// ===== tb/sv/tb_cell_list_neighbor_search.sv =====
// Testbench top for the cell list neighbour search: reset, config phases, directed and
// random operations with bursty input and a stalling receiver. Depends on clns_pkg,
// the block and cell_list_checker, which does all prediction and comparison.
`timescale 1ns / 1ps
module tb_cell_list_neighbor_search;
  import clns_pkg::*;

  logic        clk_i, rst_ni;
  logic        cfg_valid_i, cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  func_i;
  logic [5:0]  particle_id_i;
  logic [31:0] coord_x_i, coord_y_i, coord_z_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b1;
  logic [6:0]  self_id_o;
  logic [5:0]  neighbor_id_o;
  logic        found_o, last_o, status_o;
  int          fail_count, pending;
  logic [31:0] org [3];
  int          stall_mode = 0;

  cell_list_neighbor_search dut (.*);

  cell_list_checker checker_i (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .particle_id_i, .coord_x_i,
    .coord_y_i, .coord_z_i, .out_valid_i(out_valid_o), .out_ready_i,
    .self_id_i(self_id_o), .neighbor_id_i(neighbor_id_o), .found_i(found_o),
    .last_i(last_o), .status_i(status_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver stalls: phases of none, light, heavy and long-run stalls
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= ($urandom_range(0, 39) < 30) ? out_ready_i : ~out_ready_i;
    endcase
  end

  task automatic write_reg(reg_e idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx inside {REG_ORG_X, REG_ORG_Y, REG_ORG_Z}) org[int'(idx) - 1] = val;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic send(func_e fn, logic [5:0] pid, logic [31:0] x, logic [31:0] y,
                      logic [31:0] z);
    in_valid_i    <= 1'b1;
    func_i        <= fn;
    particle_id_i <= pid;
    coord_x_i     <= x;
    coord_y_i     <= y;
    coord_z_i     <= z;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic gap();
    in_valid_i <= 1'b0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  // coordinate landing in cell c (plus jitter) on an axis, when inv is the plain one
  function automatic logic [31:0] near_cell(int axis, int c);
    return org[axis] + 32'(c * 65536) + 32'($urandom_range(0, 65535)) - 32'h8000;
  endfunction

  task automatic random_phase(int count, int span);
    int burst;
    func_e fn;
    logic [31:0] x, y, z;
    int n;
    n = 0;
    burst = 0;
    while (n < count) begin
      if (burst == 0) begin
        if (n != 0) gap();
        burst = $urandom_range(1, 12);
      end
      case ($urandom_range(0, 19))
        0:              fn = FN_CLEAR;
        1, 2, 3, 4, 5, 6, 7, 8: fn = FN_INSERT;
        9, 10, 11, 12:  fn = FN_QUERY;
        default:        fn = FN_SCAN;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        x = $urandom; y = $urandom; z = $urandom;
      end else begin
        x = near_cell(0, $urandom_range(0, span) - 1);
        y = near_cell(1, $urandom_range(0, span) - 1);
        z = near_cell(2, $urandom_range(0, span) - 1);
      end
      send(fn, 6'($urandom), x, y, z);
      burst--;
      n++;
    end
    in_valid_i <= 1'b0;
    drain();
  endtask

  initial begin
    org = '{default: 32'd0};
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; func_i = '0; particle_id_i = '0;
    coord_x_i = '0; coord_y_i = '0; coord_z_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset grid 16^3
    send(FN_QUERY, 6'd0, 32'd0, 32'd0, 32'd0);
    send(FN_SCAN, 6'd5, 32'd0, 32'd0, 32'd0);
    send(FN_INSERT, 6'd5, 32'h0000_8000, 32'd0, 32'd0);
    send(FN_INSERT, 6'd7, 32'hFFFF_0001, 32'd0, 32'd0);
    send(FN_INSERT, 6'd9, 32'hFFFF_8000, 32'd0, 32'd0);
    send(FN_INSERT, 6'd63, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000);
    send(FN_INSERT, 6'd1, 32'h7FFF_FFFF, 32'd0, 32'd0);
    send(FN_INSERT, 6'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send(FN_INSERT, 6'd3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send(FN_INSERT, 6'd0, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000);
    send(FN_INSERT, 6'd5, 32'd0, 32'd0, 32'd0);
    send(FN_SCAN, 6'd5, 32'd0, 32'd0, 32'd0);
    send(FN_SCAN, 6'd3, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send(FN_QUERY, 6'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send(FN_QUERY, 6'd0, 32'h000F_0000, 32'h000F_0000, 32'h000F_0000);
    send(FN_SCAN, 6'd63, 32'h000E_0000, 32'h000E_0000, 32'h000E_0000);
    // more than 64 in one neighbourhood
    for (int i = 0; i < 64; i++)
      send(FN_INSERT, 6'(i), 32'(((i % 3) * 65536)), 32'h0001_0000, 32'h0001_0000);
    send(FN_QUERY, 6'd0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send(FN_SCAN, 6'd63, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
    send(FN_CLEAR, 6'h3F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    in_valid_i <= 1'b0;
    drain();

    random_phase(40, 17);

    // one dimension, long row, shifted origin
    write_reg(REG_DIMS, 32'd1);
    write_reg(REG_CX, 32'd4096);
    write_reg(REG_ORG_X, 32'hFFF0_0000);
    random_phase(30, 40);

    // two dimensions, small grid, dims zero behaves as one first
    write_reg(REG_DIMS, 32'd0);
    random_phase(10, 5);
    write_reg(REG_DIMS, 32'd2);
    write_reg(REG_CX, 32'd1);
    write_reg(REG_CY, 32'd4096);
    write_reg(REG_ORG_Y, 32'h8000_0000);
    random_phase(20, 5);

    // 3d with extreme origins and cell counts, flat numbers exceed the table
    write_reg(REG_DIMS, 32'd3);
    write_reg(REG_CX, 32'd7);
    write_reg(REG_CY, 32'd4096);
    write_reg(REG_CZ, 32'd4096);
    write_reg(REG_ORG_X, 32'h7FFF_FFFF);
    write_reg(REG_ORG_Y, 32'd0);
    write_reg(REG_ORG_Z, 32'hFFFF_0000);
    random_phase(27, 12);

    // coarse, fine and degenerate cell sizes
    write_reg(REG_CX, 32'd16);
    write_reg(REG_CY, 32'd16);
    write_reg(REG_CZ, 32'd16);
    write_reg(REG_ORG_X, 32'd0);
    write_reg(REG_INV, 32'hFFFF_FFFF);
    random_phase(10, 17);
    write_reg(REG_INV, 32'd1);
    random_phase(10, 17);
    write_reg(REG_INV, 32'd0);
    random_phase(10, 17);
    write_reg(REG_INV, 32'd65536);
    write_reg(REG_CZ, 32'd1);
    random_phase(30, 17);

    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule
